[hw/rtl/mcurb_pkg.sv]
// mcurb_pkg: shared types and action codes for the multi-channel uart ring buffers
// no dependencies
`default_nettype none
package mcurb_pkg;
	localparam logic [2:0] ACT_HOST_WR = 3'd0;
	localparam logic [2:0] ACT_HOST_RD = 3'd1;
	localparam logic [2:0] ACT_LINE_RX = 3'd2;
	localparam logic [2:0] ACT_LINE_TX = 3'd3;
	localparam logic [2:0] ACT_REWIND  = 3'd4;
	localparam int FILL_W = 11;

	typedef struct packed {
		logic [2:0] action;
		logic [1:0] channel;
		logic [7:0] data_in;
		logic       first_of_call;
	} item_t;

	typedef struct packed {
		logic [7:0]        data_out;
		logic              data_valid;
		logic [FILL_W-1:0] rx_fill;
		logic [FILL_W-1:0] tx_fill;
	} result_t;
endpackage
`default_nettype wire

[hw/rtl/multi_channel_uart_ring_buffers.sv]
// multi_channel_uart_ring_buffers: top level, front queue and back ring engine
// depends on mcurb_pkg, mcurb_front, mcurb_back
// each transfer in gives one transfer out; the back part handles one item at a time,
// stepping through pointer update, registered ram read and result, and can be held by output stall.
// a two-entry queue in front keeps accepting while the back part works, until both entries are full.
`default_nettype none
module multi_channel_uart_ring_buffers #(
	parameter int DEPTH_A = 256,
	parameter int DEPTH_B = 1024
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [3:0]  cfg_wdata,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [2:0]  action,
	input  wire logic [1:0]  channel,
	input  wire logic [7:0]  data_in,
	input  wire logic        first_of_call,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [7:0]       data_out,
	output logic             data_valid,
	output logic [10:0]      rx_fill,
	output logic [10:0]      tx_fill
);
	logic [3:0] enable_q;
	mcurb_pkg::item_t   in_item, q_item;
	mcurb_pkg::result_t res;
	logic q_valid, q_take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= '0;
		end else if (cfg_we) begin
			enable_q <= cfg_wdata;
		end
	end

	assign in_item = '{action: action, channel: channel, data_in: data_in,
		first_of_call: first_of_call};

	mcurb_front u_front (.clk(clk), .arst_n(arst_n), .in_valid(in_valid),
		.in_stall(in_stall), .in_item(in_item), .q_valid(q_valid), .q_item(q_item),
		.q_take(q_take));

	mcurb_back #(.DEPTH_A(DEPTH_A), .DEPTH_B(DEPTH_B)) u_back (.clk(clk),
		.arst_n(arst_n), .channel_enable(enable_q), .q_valid(q_valid), .q_item(q_item),
		.q_take(q_take), .out_valid(out_valid), .out_stall(out_stall), .out_res(res));

	assign data_out   = res.data_out;
	assign data_valid = res.data_valid;
	assign rx_fill    = res.rx_fill;
	assign tx_fill    = res.tx_fill;
endmodule
`default_nettype wire

[hw/rtl/mcurb_ram.sv]
// mcurb_ram: generic single-port-write, single-read ram with registered read
// no dependencies
`default_nettype none
module mcurb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 512
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

[hw/rtl/mcurb_front.sv]
// mcurb_front: input transfer stage and two-entry item queue
// depends on mcurb_pkg
`default_nettype none
module mcurb_front (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_stall,
	input  wire mcurb_pkg::item_t in_item,
	output logic                  q_valid,
	output mcurb_pkg::item_t      q_item,
	input  wire logic             q_take
);
	mcurb_pkg::item_t buf_q [2];
	logic             rd_q, wr_q;
	logic [1:0]       cnt_q;
	logic             push;
	assign in_stall = (cnt_q == 2'd2);
	assign push     = in_valid && !in_stall;
	assign q_valid  = (cnt_q != 2'd0);
	assign q_item   = buf_q[rd_q];
	always_ff @(posedge clk) begin
		if (push) begin
			buf_q[wr_q] <= in_item;
		end
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q  <= 1'b0;
			wr_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (q_take) begin
				rd_q <= ~rd_q;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, q_take};
		end
	end
endmodule
`default_nettype wire

[hw/rtl/mcurb_back.sv]
// mcurb_back: ring pointer state, ring memories and result register
// depends on mcurb_pkg and mcurb_ram
`default_nettype none
module mcurb_back #(
	parameter int DEPTH_A = 256,
	parameter int DEPTH_B = 1024
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic [3:0]       channel_enable,
	input  wire logic             q_valid,
	input  wire mcurb_pkg::item_t q_item,
	output logic                  q_take,
	output logic                  out_valid,
	input  wire logic             out_stall,
	output mcurb_pkg::result_t    out_res
);
	localparam int AW_A = $clog2(2 * DEPTH_A);
	localparam int AW_B = $clog2(2 * DEPTH_B);
	localparam int DMAX = (DEPTH_A > DEPTH_B) ? DEPTH_A : DEPTH_B;
	localparam int PW   = $clog2(DMAX) + 2;
	localparam logic [PW-1:0] DA = PW'(DEPTH_A);
	localparam logic [PW-1:0] DB = PW'(DEPTH_B);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_READ = 2'd1;
	localparam logic [1:0] ST_OUT  = 2'd2;

	logic [1:0]    st_q;
	logic [PW-1:0] txp_q [4];
	logic [PW-1:0] txc_q [4];
	logic [PW-1:0] rxp_q [4];
	logic [PW-1:0] rxc_q [4];
	logic [3:0]    drop_q;
	logic [PW-1:0] rwc_q;
	logic          pop_tx_q, pop_ok_q;
	logic [1:0]    ch_q;
	mcurb_pkg::result_t res_q;

	mcurb_pkg::item_t it;
	logic [1:0]    ch;
	logic [PW-1:0] d, txc, rxc, txp, rxp;
	logic          en, is_b;
	logic [PW:0]   wsum;
	logic [PW-1:0] wpos, rpos;
	logic          twe, rwe;
	logic [7:0]    rd_ta, rd_ra, rd_tb, rd_rb, popped;
	logic [AW_A-1:0] wa_a, ra_a;
	logic [AW_B-1:0] wa_b, ra_b;

	assign it   = q_item;
	assign ch   = it.channel;
	assign is_b = ch[1];
	assign d    = is_b ? DB : DA;
	assign txc  = txc_q[ch];
	assign rxc  = rxc_q[ch];
	assign txp  = txp_q[ch];
	assign rxp  = rxp_q[ch];
	assign en   = channel_enable[ch];
	assign q_take = (st_q == ST_IDLE) && q_valid;

	logic [PW-1:0] wbase;
	logic          wfirst_full;
	assign wfirst_full = it.first_of_call && (txc >= d);
	assign twe = q_take && (it.action == mcurb_pkg::ACT_HOST_WR) && !wfirst_full
		&& !(drop_q[ch] && !it.first_of_call) && (txc < d);
	assign rwe = q_take && (it.action == mcurb_pkg::ACT_LINE_RX) && en && (rxc < d);
	assign wbase = (it.action == mcurb_pkg::ACT_HOST_WR) ? txp : rxp;
	assign wsum  = {1'b0, wbase} + {1'b0, (it.action == mcurb_pkg::ACT_HOST_WR) ? txc : rxc};
	assign wpos  = (wsum >= {1'b0, d}) ? PW'(wsum - {1'b0, d}) : wsum[PW-1:0];
	assign rpos  = (it.action == mcurb_pkg::ACT_LINE_TX) ? txp : rxp;

	assign wa_a = is_b ? '0 : AW_A'({ch[0], wpos[AW_A-2:0]}) + (ch[0] ? AW_A'(DEPTH_A) : '0)
		- AW_A'({ch[0], {(AW_A-1){1'b0}}});
	assign ra_a = is_b ? '0 : AW_A'({ch[0], rpos[AW_A-2:0]}) + (ch[0] ? AW_A'(DEPTH_A) : '0)
		- AW_A'({ch[0], {(AW_A-1){1'b0}}});
	assign wa_b = AW_B'(wpos) + (ch[0] ? AW_B'(DEPTH_B) : '0);
	assign ra_b = AW_B'(rpos) + (ch[0] ? AW_B'(DEPTH_B) : '0);

	mcurb_ram #(.WIDTH(8), .DEPTH(2 * DEPTH_A)) u_tx_a (.clk(clk), .we(twe && !is_b),
		.waddr(wa_a), .wdata(it.data_in), .raddr(ra_a), .rdata(rd_ta));
	mcurb_ram #(.WIDTH(8), .DEPTH(2 * DEPTH_A)) u_rx_a (.clk(clk), .we(rwe && !is_b),
		.waddr(wa_a), .wdata(it.data_in), .raddr(ra_a), .rdata(rd_ra));
	mcurb_ram #(.WIDTH(8), .DEPTH(2 * DEPTH_B)) u_tx_b (.clk(clk), .we(twe && is_b),
		.waddr(wa_b), .wdata(it.data_in), .raddr(ra_b), .rdata(rd_tb));
	mcurb_ram #(.WIDTH(8), .DEPTH(2 * DEPTH_B)) u_rx_b (.clk(clk), .we(rwe && is_b),
		.waddr(wa_b), .wdata(it.data_in), .raddr(ra_b), .rdata(rd_rb));

	assign popped = pop_tx_q ? (ch_q[1] ? rd_tb : rd_ta) : (ch_q[1] ? rd_rb : rd_ra);
	assign out_valid = (st_q == ST_OUT);
	assign out_res   = res_q;

	logic [PW-1:0] nrxp, nrxc, ntxp, ntxc, nrwc, back, rsum;
	logic [1:0]    rch;
	logic          pop;
	logic [PW:0]   rwsum;
	always_comb begin
		nrxp = rxp;
		nrxc = rxc;
		ntxp = txp;
		ntxc = txc;
		nrwc = rwc_q;
		rch  = ch;
		pop  = 1'b0;
		back = (rwc_q == DB) ? '0 : rwc_q;
		rwsum = '0;
		rsum  = '0;
		case (it.action)
			mcurb_pkg::ACT_HOST_WR: begin
				if (wfirst_full) begin
					ntxc = '0;
				end else if (twe) begin
					ntxc = txc + 1'b1;
				end
			end
			mcurb_pkg::ACT_HOST_RD: begin
				if (rxc != '0) begin
					pop  = 1'b1;
					nrxc = rxc - 1'b1;
					nrxp = (rxp + 1'b1 == d) ? '0 : rxp + 1'b1;
					if (ch == 2'd2) begin
						if (it.first_of_call) begin
							nrwc = PW'(1);
						end else if (rwc_q < DB) begin
							nrwc = rwc_q + 1'b1;
						end
					end
				end
			end
			mcurb_pkg::ACT_LINE_RX: begin
				if (en) begin
					nrxc = (rxc < d) ? rxc + 1'b1 : '0;
				end
			end
			mcurb_pkg::ACT_LINE_TX: begin
				if (en && txc != '0) begin
					pop  = 1'b1;
					ntxc = txc - 1'b1;
					ntxp = (txp + 1'b1 == d) ? '0 : txp + 1'b1;
				end
			end
			mcurb_pkg::ACT_REWIND: begin
				rch  = 2'd2;
				rsum = rxp_q[2] + DB - back;
				nrxp = (rsum >= DB) ? rsum - DB : rsum;
				rwsum = {1'b0, rxc_q[2]} + {1'b0, rwc_q};
				nrxc = (rwsum > {1'b0, DB}) ? DB : rwsum[PW-1:0];
				ntxp = txp_q[2];
				ntxc = txc_q[2];
				nrwc = '0;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (q_take) begin
			ch_q     <= ch;
			pop_tx_q <= (it.action == mcurb_pkg::ACT_LINE_TX);
			pop_ok_q <= pop;
			res_q.rx_fill <= 11'(nrxc);
			res_q.tx_fill <= 11'(ntxc);
		end
		if (st_q == ST_READ) begin
			res_q.data_out   <= pop_ok_q ? popped : 8'd0;
			res_q.data_valid <= pop_ok_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= ST_IDLE;
			drop_q <= '0;
			rwc_q  <= '0;
			for (int i = 0; i < 4; i++) begin
				txp_q[i] <= '0;
				txc_q[i] <= '0;
				rxp_q[i] <= '0;
				rxc_q[i] <= '0;
			end
		end else begin
			case (st_q)
				ST_IDLE: begin
					if (q_take) begin
						st_q <= ST_READ;
						rxp_q[rch] <= nrxp;
						rxc_q[rch] <= nrxc;
						txp_q[rch] <= ntxp;
						txc_q[rch] <= ntxc;
						rwc_q      <= nrwc;
						if (it.action == mcurb_pkg::ACT_HOST_WR && it.first_of_call) begin
							drop_q[ch] <= wfirst_full;
						end
					end
				end
				ST_READ: st_q <= ST_OUT;
				ST_OUT: begin
					if (!out_stall) begin
						st_q <= ST_IDLE;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

[tb/multi_channel_uart_ring_buffers_tb.sv]
// multi_channel_uart_ring_buffers_tb: self-checking testbench for the four-channel uart ring buffers
// drives a directed table and random host/line traffic, checks every transfer out against a predictor
// depends on mcurb_pkg and multi_channel_uart_ring_buffers
`timescale 1ns / 100ps
`default_nettype none
module multi_channel_uart_ring_buffers_tb;
	localparam int DEPTH_A = 256;
	localparam int DEPTH_B = 1024;
	localparam int RANDOM_ITEMS = 1270;
	localparam int CYCLE_LIMIT = 400000;
	localparam logic [2:0] ACT_UNDEF_LO = 3'd5;
	localparam logic [2:0] ACT_UNDEF    = 3'd6;
	localparam logic [2:0] ACT_UNDEF_HI = 3'd7;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [3:0] cfg_wdata = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [2:0] action = '0;
	logic [1:0] channel = '0;
	logic [7:0] data_in = '0;
	logic first_of_call = 1'b0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [7:0] data_out;
	logic data_valid;
	logic [10:0] rx_fill;
	logic [10:0] tx_fill;

	multi_channel_uart_ring_buffers #(.DEPTH_A(DEPTH_A), .DEPTH_B(DEPTH_B)) uut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.in_valid(in_valid), .in_stall(in_stall), .action(action), .channel(channel),
		.data_in(data_in), .first_of_call(first_of_call), .out_valid(out_valid),
		.out_stall(out_stall), .data_out(data_out), .data_valid(data_valid),
		.rx_fill(rx_fill), .tx_fill(tx_fill)
	);

	always #2 clk = ~clk;

	// predictor state
	logic [7:0] tx_ring [4][DEPTH_B];
	logic [7:0] rx_ring [4][DEPTH_B];
	int tx_head [4];
	int tx_level [4];
	int rx_head [4];
	int rx_level [4];
	bit tx_dropping [4];
	int rewind_span;
	logic [3:0] enabled_chans;
	bit rx_written [4][DEPTH_B];

	mcurb_pkg::result_t pending_results [$];
	int mismatches = 0;
	int cycles = 0;
	int n_sent = 0;
	int n_recv = 0;
	int n_popped = 0;
	bit long_hold = 1'b0;

	function automatic int ring_depth(input logic [1:0] ch);
		return (ch < 2) ? DEPTH_A : DEPTH_B;
	endfunction

	function automatic void reset_rings();
		for (int c = 0; c < 4; c++) begin
			tx_head[c] = 0; tx_level[c] = 0; rx_head[c] = 0; rx_level[c] = 0;
			tx_dropping[c] = 0;
			for (int i = 0; i < DEPTH_B; i++)
				rx_written[c][i] = 0;
		end
		rewind_span = 0;
		enabled_chans = '0;
	endfunction

	function automatic mcurb_pkg::result_t predict_ring_event(input mcurb_pkg::item_t it);
		mcurb_pkg::result_t r;
		int d;
		int p;
		logic [1:0] ch;
		bit had;
		ch = it.channel;
		d = ring_depth(ch);
		r = '0;
		case (it.action)
			mcurb_pkg::ACT_HOST_WR: begin
				if (it.first_of_call) begin
					tx_dropping[ch] = 0;
					if (tx_level[ch] >= d) begin
						tx_level[ch] = 0;
						tx_dropping[ch] = 1;
					end
				end
				if (!tx_dropping[ch] && tx_level[ch] < d) begin
					tx_ring[ch][(tx_head[ch] + tx_level[ch]) % d] = it.data_in;
					tx_level[ch]++;
				end
			end
			mcurb_pkg::ACT_HOST_RD: begin
				had = rx_level[ch] > 0;
				if (had) begin
					r.data_out = rx_ring[ch][rx_head[ch]];
					r.data_valid = 1'b1;
					rx_head[ch] = (rx_head[ch] + 1) % d;
					rx_level[ch]--;
					if (ch == 2) begin
						if (it.first_of_call)
							rewind_span = 1;
						else if (rewind_span < DEPTH_B)
							rewind_span++;
					end
				end
			end
			mcurb_pkg::ACT_LINE_RX: begin
				if (enabled_chans[ch]) begin
					if (rx_level[ch] < d) begin
						p = (rx_head[ch] + rx_level[ch]) % d;
						rx_ring[ch][p] = it.data_in;
						rx_written[ch][p] = 1;
						rx_level[ch]++;
					end else
						rx_level[ch] = 0;
				end
			end
			mcurb_pkg::ACT_LINE_TX: begin
				if (enabled_chans[ch] && tx_level[ch] > 0) begin
					r.data_out = tx_ring[ch][tx_head[ch]];
					r.data_valid = 1'b1;
					tx_head[ch] = (tx_head[ch] + 1) % d;
					tx_level[ch]--;
				end
			end
			mcurb_pkg::ACT_REWIND: begin
				ch = 2;
				rx_head[2] = (rx_head[2] + DEPTH_B - (rewind_span % DEPTH_B)) % DEPTH_B;
				rx_level[2] = rx_level[2] + rewind_span;
				if (rx_level[2] > DEPTH_B)
					rx_level[2] = DEPTH_B;
				rewind_span = 0;
			end
			default: ;
		endcase
		r.rx_fill = rx_level[ch][10:0];
		r.tx_fill = tx_level[ch][10:0];
		return r;
	endfunction

	// a rewind must not expose never-written receive slots of channel 2
	function automatic bit rewind_is_safe();
		int lvl;
		int pos;
		lvl = rx_level[2] + rewind_span;
		if (lvl > DEPTH_B)
			lvl = DEPTH_B;
		pos = (rx_head[2] + DEPTH_B - (rewind_span % DEPTH_B)) % DEPTH_B;
		for (int i = 0; i < lvl; i++)
			if (!rx_written[2][(pos + i) % DEPTH_B])
				return 0;
		return 1;
	endfunction

	task automatic send_item(input mcurb_pkg::item_t it, input bit has_known,
			input mcurb_pkg::result_t known);
		mcurb_pkg::result_t r;
		r = predict_ring_event(it);
		if (has_known && r != known) begin
			mismatches++;
			if (mismatches <= 10)
				$display("table row mismatch: predicted %h typed %h", r, known);
		end
		pending_results.push_back(r);
		in_valid <= 1'b1;
		action <= it.action;
		channel <= it.channel;
		data_in <= it.data_in;
		first_of_call <= it.first_of_call;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		n_sent++;
	endtask

	task automatic sender_gap();
		int g;
		g = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
		if ($urandom_range(0, 2) == 0)
			g = 0;
		if (g > 0) begin
			in_valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
	endtask

	task automatic write_enable(input logic [3:0] v);
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		enabled_chans = v;
	endtask

	// receiver: random stall, one long hold-off
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				n_recv++;
				if (pending_results.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected transfer out: %h %b %d %d",
							data_out, data_valid, rx_fill, tx_fill);
				end else begin
					mcurb_pkg::result_t e;
					e = pending_results.pop_front();
					if (e.data_valid) n_popped++;
					if (e.data_out !== data_out || e.data_valid !== data_valid ||
							e.rx_fill !== rx_fill || e.tx_fill !== tx_fill) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch: expected %h %b %0d %0d got %h %b %0d %0d",
								e.data_out, e.data_valid, e.rx_fill, e.tx_fill,
								data_out, data_valid, rx_fill, tx_fill);
					end
				end
			end
		end
	end

	initial begin
		int hold;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (long_hold) begin
				long_hold = 1'b0;
				out_stall <= 1'b1;
				for (hold = 0; hold < 200; hold++)
					@(posedge clk);
				out_stall <= 1'b0;
			end else
				out_stall <= ($urandom_range(0, 3) == 0) ?
					($urandom_range(0, 15) == 0 ? 1'b1 : 1'($urandom_range(0, 1))) : 1'b0;
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("FAILED: results differ");
			$finish;
		end
	end

	typedef struct {
		mcurb_pkg::item_t it;
		bit has_known;
		mcurb_pkg::result_t known;
	} stim_row_t;

	stim_row_t stim_table [$];

	function automatic mcurb_pkg::item_t mk(input logic [2:0] a, input logic [1:0] c,
			input logic [7:0] d, input logic f);
		mcurb_pkg::item_t it;
		it.action = a; it.channel = c; it.data_in = d; it.first_of_call = f;
		return it;
	endfunction

	function automatic mcurb_pkg::result_t res(input logic [7:0] d, input logic v, input int rx,
			input int tx);
		mcurb_pkg::result_t r;
		r.data_out = d; r.data_valid = v; r.rx_fill = rx[10:0]; r.tx_fill = tx[10:0];
		return r;
	endfunction

	function automatic void row(input mcurb_pkg::item_t it, input bit k,
			input mcurb_pkg::result_t r);
		stim_row_t s;
		s.it = it; s.has_known = k; s.known = r;
		stim_table.push_back(s);
	endfunction

	initial begin
		mcurb_pkg::item_t it;
		int ch;
		int len;
		int kind;
		int n_items;
		reset_rings();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty reads with everything disabled, then extremes and codes
		row(mk(mcurb_pkg::ACT_HOST_RD, 2'd0, 8'h00, 1'b1), 1, res(8'h00, 0, 0, 0));
		row(mk(mcurb_pkg::ACT_LINE_TX, 2'd3, 8'hff, 1'b0), 1, res(8'h00, 0, 0, 0));
		row(mk(mcurb_pkg::ACT_LINE_RX, 2'd1, 8'hff, 1'b0), 1, res(8'h00, 0, 0, 0));
		row(mk(ACT_UNDEF,              2'd2, 8'h55, 1'b1), 1, res(8'h00, 0, 0, 0));
		row(mk(ACT_UNDEF_HI,           2'd1, 8'haa, 1'b0), 1, res(8'h00, 0, 0, 0));
		row(mk(ACT_UNDEF_LO,           2'd3, 8'h0f, 1'b1), 1, res(8'h00, 0, 0, 0));
		row(mk(mcurb_pkg::ACT_REWIND,  2'd0, 8'h00, 1'b0), 1, res(8'h00, 0, 0, 0));
		row(mk(mcurb_pkg::ACT_HOST_WR, 2'd0, 8'hff, 1'b1), 1, res(8'h00, 0, 0, 1));
		row(mk(mcurb_pkg::ACT_HOST_WR, 2'd0, 8'h00, 1'b0), 1, res(8'h00, 0, 0, 2));
		row(mk(mcurb_pkg::ACT_HOST_WR, 2'd3, 8'ha5, 1'b1), 1, res(8'h00, 0, 0, 1));
		row(mk(mcurb_pkg::ACT_LINE_TX, 2'd0, 8'h00, 1'b0), 1, res(8'h00, 0, 0, 2));
		foreach (stim_table[i])
			send_item(stim_table[i].it, stim_table[i].has_known, stim_table[i].known);
		stim_table.delete();

		write_enable(4'hf);
		row(mk(mcurb_pkg::ACT_LINE_TX, 2'd0, 8'h00, 1'b0), 1, res(8'hff, 1, 0, 1));
		row(mk(mcurb_pkg::ACT_LINE_TX, 2'd0, 8'h00, 1'b0), 1, res(8'h00, 1, 0, 0));
		row(mk(mcurb_pkg::ACT_LINE_TX, 2'd0, 8'h00, 1'b0), 1, res(8'h00, 0, 0, 0));
		row(mk(mcurb_pkg::ACT_LINE_RX, 2'd2, 8'h80, 1'b0), 1, res(8'h00, 0, 1, 0));
		row(mk(mcurb_pkg::ACT_LINE_RX, 2'd2, 8'h7f, 1'b0), 1, res(8'h00, 0, 2, 0));
		row(mk(mcurb_pkg::ACT_HOST_RD, 2'd2, 8'h00, 1'b1), 1, res(8'h80, 1, 1, 0));
		row(mk(mcurb_pkg::ACT_HOST_RD, 2'd2, 8'h00, 1'b0), 1, res(8'h7f, 1, 0, 0));
		row(mk(mcurb_pkg::ACT_HOST_RD, 2'd2, 8'h00, 1'b0), 1, res(8'h00, 0, 0, 0));
		row(mk(mcurb_pkg::ACT_REWIND,  2'd1, 8'h00, 1'b0), 1, res(8'h00, 0, 2, 0));
		row(mk(mcurb_pkg::ACT_HOST_RD, 2'd2, 8'h00, 1'b1), 0, res(0, 0, 0, 0));
		foreach (stim_table[i])
			send_item(stim_table[i].it, stim_table[i].has_known, stim_table[i].known);
		stim_table.delete();

		// fill channel 0 tx and channel 1 rx to full, then overflow both
		for (int i = 0; i < DEPTH_A + 3; i++)
			send_item(mk(mcurb_pkg::ACT_HOST_WR, 2'd0, 8'($urandom_range(0, 255)), i == 0),
				0, '0);
		send_item(mk(mcurb_pkg::ACT_HOST_WR, 2'd0, 8'h11, 1'b1), 1, res(8'h00, 0, 0, 0));
		send_item(mk(mcurb_pkg::ACT_HOST_WR, 2'd0, 8'h22, 1'b0), 1, res(8'h00, 0, 0, 0));
		for (int i = 0; i < DEPTH_A + 1; i++)
			send_item(mk(mcurb_pkg::ACT_LINE_RX, 2'd1, 8'($urandom_range(0, 255)), 1'b0),
				0, '0);
		long_hold = 1'b1;
		for (int i = 0; i < 40; i++)
			send_item(mk(mcurb_pkg::ACT_LINE_RX, 2'd1, 8'($urandom_range(0, 255)), 1'b0),
				0, '0);

		// random phases, several enable settings
		n_items = 0;
		for (int phase = 0; phase < 6; phase++) begin
			write_enable(phase == 0 ? 4'h0 : phase == 1 ? 4'hf : 4'($urandom_range(0, 15)));
			while (n_items < RANDOM_ITEMS * (phase + 1) / 6) begin
				ch = $urandom_range(0, 3);
				len = $urandom_range(1, 12);
				kind = $urandom_range(0, 9);
				for (int i = 0; i < len; i++) begin
					if (kind < 2)
						it = mk(mcurb_pkg::ACT_HOST_WR, 2'(ch), 8'($urandom_range(0, 255)),
							i == 0);
					else if (kind < 4)
						it = mk(mcurb_pkg::ACT_HOST_RD, 2'(ch), 8'($urandom_range(0, 255)),
							i == 0);
					else if (kind < 6)
						it = mk(mcurb_pkg::ACT_LINE_RX, 2'(ch), 8'($urandom_range(0, 255)),
							1'($urandom_range(0, 1)));
					else if (kind < 8)
						it = mk(mcurb_pkg::ACT_LINE_TX, 2'(ch), 8'($urandom_range(0, 255)),
							1'($urandom_range(0, 1)));
					else if (kind == 8)
						it = mk(mcurb_pkg::ACT_REWIND, 2'(ch), 8'($urandom_range(0, 255)),
							1'($urandom_range(0, 1)));
					else
						it = mk(3'($urandom_range(0, 7)), 2'(ch), 8'($urandom_range(0, 255)),
							1'($urandom_range(0, 1)));
					if (it.action == mcurb_pkg::ACT_REWIND && !rewind_is_safe())
						it.action = mcurb_pkg::ACT_HOST_RD;
					send_item(it, 0, '0);
					n_items++;
					sender_gap();
				end
			end
		end

		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		$display("sent %0d items, checked %0d transfers out, %0d carried a byte",
			n_sent, n_recv, n_popped);
		$display("covered overflow on both rings, rewinds, disabled channels and a long hold-off");
		if (mismatches == 0 && pending_results.size() == 0)
			$display("PASSED: all results match");
		else begin
			$display("%0d mismatches", mismatches);
			$display("FAILED: results differ");
		end
		$finish;
	end
endmodule
`default_nettype wire
